>>> src/mfpf_pkg.sv
// Shared constants, state codes and arithmetic helpers of the fan poll framer.
package mfpf_pkg;

    localparam int SLOT_COUNT = 6;
    localparam int FRAME_LEN  = 8;
    localparam int HDR_LEN    = 6;

    localparam logic [2:0]  SLOT_LAST       = 3'(SLOT_COUNT - 1);
    localparam logic [2:0]  FRAME_LAST      = 3'(FRAME_LEN - 1);
    localparam logic [2:0]  HDR_LAST        = 3'(HDR_LEN - 1);
    localparam logic [6:0]  FAN_COUNT_RESET = 7'd3;
    localparam logic [15:0] SPEED_LIMIT     = 16'd60;
    localparam logic [15:0] REG_BASE        = 16'hD000;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] READ_DATA       = 16'h0101;
    localparam logic [7:0]  ADDR_BROADCAST  = 8'h00;
    localparam logic [7:0]  FUNC_WRITE      = 8'h06;
    localparam logic [7:0]  FUNC_READ       = 8'h04;

    // speed * 65536 / 100 is speed * 655 plus speed * 36 / 100; the latter
    // uses the reciprocal 5243 / 2^19, exact for the clamped range.
    localparam logic [15:0] SCALE_INT   = 16'd655;
    localparam logic [24:0] SCALE_FRAC  = 25'd188748;
    localparam int          SCALE_SHIFT = 19;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_MODULO = 5'b00010,
        ST_BUILD  = 5'b00100,
        ST_CRC    = 5'b01000,
        ST_SEND   = 5'b10000
    } state_t;

    function automatic logic [7:0] read_offset(input logic [2:0] slot);
        logic [7:0] offset;
        unique case (slot)
            3'd1:    offset = 8'h10;
            3'd2:    offset = 8'h11;
            3'd3:    offset = 8'h16;
            3'd4:    offset = 8'h1A;
            3'd5:    offset = 8'h21;
            default: offset = 8'h01;
        endcase
        return offset;
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++)
        begin
            crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
        end
        return crc;
    endfunction

endpackage

>>> src/modbus_fan_poll_framer.sv
// Top level of the fan poll framer: sequencer, shared remainder and CRC units, byte output.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------
//  in      | input     | in_valid/in_stall  | demand_speed
//  out     | output    | out_valid/out_stall| frame_byte, last_byte
//  cfg     | input     | cfg_we             | cfg_wdata (fan_count)
//
// After acceptance a poll passes through the build state, the CRC state and the send state, and
// the next poll is accepted only once the last byte of the frame has left. A wrap of the command
// slot adds the modulo state before the build state, because the fan remainder runs one bit a cycle.
// The CRC unit folds one frame byte per cycle over the six header bytes.
// Reset clears the sequencer, the slot and fan counters, and sets the fan count to 3.
// A stalled output holds its byte; the input stays stalled until the eighth byte goes out.
module modbus_fan_poll_framer
    import mfpf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] demand_speed,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  frame_byte,
    output logic        last_byte
);

    state_t      state_reg, state_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [2:0]  slot_reg, slot_next;
    logic [6:0]  fan_index_reg, fan_index_next;
    logic [6:0]  fan_count_reg;
    logic [5:0]  speed_reg, speed_next;
    logic [7:0]  dvd_reg, dvd_next;
    logic [6:0]  rem_reg, rem_next;
    logic [47:0] hdr_reg, hdr_next;
    logic [15:0] crc_reg, crc_next;

    logic        in_accept;
    logic        out_accept;
    logic [7:0]  trial;
    logic [24:0] frac_prod;
    logic [15:0] write_data;
    logic [15:0] reg_addr;
    logic [7:0]  fan_addr;

    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid && !out_stall;
    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = (state_reg == ST_SEND);
    assign last_byte  = (state_reg == ST_SEND) && (cnt_reg == FRAME_LAST);

    always_comb
    begin
        if (cnt_reg == 3'(HDR_LEN))
        begin
            frame_byte = crc_reg[7:0];
        end
        else if (cnt_reg == FRAME_LAST)
        begin
            frame_byte = crc_reg[15:8];
        end
        else
        begin
            frame_byte = hdr_reg[47:40];
        end
    end

    assign trial      = {rem_reg, dvd_reg[7]};
    assign frac_prod  = 25'(speed_reg) * SCALE_FRAC;
    assign write_data = 16'(16'(speed_reg) * SCALE_INT) + 16'(frac_prod[24:SCALE_SHIFT]);
    assign reg_addr   = REG_BASE + 16'(read_offset(slot_reg));
    assign fan_addr   = 8'(fan_index_reg) + 8'd1;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        slot_next      = slot_reg;
        fan_index_next = fan_index_reg;
        speed_next     = speed_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        hdr_next       = hdr_reg;
        crc_next       = crc_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (fan_count_reg != 7'd0))
                begin
                    speed_next = (demand_speed > SPEED_LIMIT) ? SPEED_LIMIT[5:0]
                                                              : demand_speed[5:0];
                    cnt_next   = 3'd0;
                    dvd_next   = 8'(fan_index_reg) + 8'd1;
                    rem_next   = 7'd0;
                    if (slot_reg == SLOT_LAST)
                    begin
                        slot_next  = 3'd0;
                        state_next = ST_MODULO;
                    end
                    else
                    begin
                        slot_next  = slot_reg + 3'd1;
                        state_next = ST_BUILD;
                    end
                end
            end
            ST_MODULO:
            begin
                dvd_next = {dvd_reg[6:0], 1'b0};
                if (trial >= {1'b0, fan_count_reg})
                begin
                    rem_next = 7'(trial - {1'b0, fan_count_reg});
                end
                else
                begin
                    rem_next = trial[6:0];
                end
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                begin
                    fan_index_next = rem_next;
                    cnt_next       = 3'd0;
                    state_next     = ST_BUILD;
                end
            end
            ST_BUILD:
            begin
                if (slot_reg == 3'd0)
                begin
                    hdr_next = {ADDR_BROADCAST, FUNC_WRITE, reg_addr, write_data};
                end
                else
                begin
                    hdr_next = {fan_addr, FUNC_READ, reg_addr, READ_DATA};
                end
                crc_next   = CRC_INIT;
                cnt_next   = 3'd0;
                state_next = ST_CRC;
            end
            ST_CRC:
            begin
                crc_next = crc_byte(crc_reg, hdr_reg[47:40]);
                hdr_next = {hdr_reg[39:0], hdr_reg[47:40]};
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == HDR_LAST)
                begin
                    cnt_next   = 3'd0;
                    state_next = ST_SEND;
                end
            end
            ST_SEND:
            begin
                if (out_accept)
                begin
                    hdr_next = {hdr_reg[39:0], hdr_reg[47:40]};
                    cnt_next = cnt_reg + 3'd1;
                    if (cnt_reg == FRAME_LAST)
                    begin
                        cnt_next   = 3'd0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 3'd0;
            slot_reg      <= 3'd0;
            fan_index_reg <= 7'd0;
            fan_count_reg <= FAN_COUNT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            slot_reg      <= slot_next;
            fan_index_reg <= fan_index_next;
            if (cfg_we)
            begin
                fan_count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        speed_reg <= speed_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        hdr_reg   <= hdr_next;
        crc_reg   <= crc_next;
    end

endmodule

>>> src/mfpf_checker.sv
// Port-level checker of the fan poll framer and its bind to the top level.
module mfpf_checker
    import mfpf_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  frame_byte,
    input logic        last_byte
);

    // An accepted poll never shows a result in the very next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !out_valid)
        else $error("result appeared right after input transaction");

    // The input stays stalled while a frame is being delivered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open during frame delivery");

    // The final byte ends the frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last_byte) |=> !out_valid)
        else $error("output still valid after last byte");

    // Bytes of a frame follow each other without gaps.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_byte) |=> out_valid)
        else $error("gap inside a frame");

    // A stalled output transaction holds its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(frame_byte) && $stable(last_byte)))
        else $error("stalled output changed");

endmodule

bind modbus_fan_poll_framer mfpf_checker u_mfpf_checker (.*);
